FILE: rtl/averaged_spectrum_analyzer_defines.svh
// Assertion macros used by the analyser top level.
`ifndef AVERAGED_SPECTRUM_ANALYZER_DEFINES_SVH
`define AVERAGED_SPECTRUM_ANALYZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/asa_pkg.sv
package asa_pkg;

  localparam int WinLen     = 128;
  localparam int WinLenM1   = WinLen - 1;
  localparam int LogLen     = $clog2(WinLen);
  localparam int HalfLen    = WinLen / 2;
  localparam int LogHalf    = LogLen - 1;
  localparam int StageW     = $clog2(LogLen);
  localparam int SampleBits = 16;
  localparam int InShift    = SampleBits - 6;
  localparam int FftW       = 32;
  localparam int SumW       = 56;
  localparam int DivW       = 58;
  localparam int DvsW       = 32;
  localparam int RootW      = DivW / 2;
  localparam int LevelW     = 13;
  localparam int FramesW    = 24;
  localparam int CountW     = FramesW + 1;
  localparam int WisW       = 18;
  localparam int CfgDataW   = 24;
  localparam int SigTypeW   = 2;
  localparam int ScaleShift = 52;

  localparam logic [63:0] Q30One   = 64'd1 << 30;
  localparam logic [63:0] TwoPiQ29 = 64'd3373259426;
  localparam logic [63:0] TwStep   = 64'd1 << (32 - LogLen);
  localparam logic [22:0] LevelK   = 23'd6313057;
  localparam int LevelMin = -2880;
  localparam int LevelMax = 768;
  localparam logic [DivW-1:0] MagFloor = DivW'(4);
  localparam logic [SigTypeW-1:0] SigSine = SigTypeW'(1);
  localparam logic [SigTypeW-1:0] SigTypeReset = SigTypeW'(1);
  localparam logic [FramesW-1:0] MeasFramesReset = FramesW'(48000);

  typedef enum logic [0:0] {
    CfgSignalType = 1'b0,
    CfgMeasFrames = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    StIdle, StWin,
    StBfRdB, StBfRdA, StBfMul0, StBfMul1, StBfMul2, StBfMul3, StBfTw, StBfWrA, StBfWrB,
    StMgRd, StMgSq0, StMgSq1, StMgRoot, StMgRootWait, StMgScLo, StMgScHi, StMgAcc, StCheck,
    StExRd, StExDiv, StExDivWait, StExLogWait, StExEnd
  } top_state_e;

  typedef enum logic [2:0] {
    LgIdle, LgNorm, LgSqr, LgMul, LgRnd
  } log_state_e;

  typedef logic [15:0] hann_rom_t [WinLen];
  typedef logic signed [FftW-1:0] tw_rom_t [HalfLen];

  // Returns {cos, sin} in Q30 for a phase in Q32 turns.
  function automatic logic [63:0] cos_sin_f(input logic [31:0] p);
    logic [63:0] r, a, x, x2, sn, cs, tmp;
    logic [31:0] co, si;
    r  = {34'd0, p[29:0]};
    a  = (r < (64'd1 << 29)) ? r : ((64'd1 << 30) - r);
    x  = (a * TwoPiQ29) >> 31;
    x2 = (x * x) >> 30;
    sn = Q30One;
    sn = Q30One - ((x2 * sn) >> 30) / 64'd72;
    sn = Q30One - ((x2 * sn) >> 30) / 64'd42;
    sn = Q30One - ((x2 * sn) >> 30) / 64'd20;
    sn = Q30One - ((x2 * sn) >> 30) / 64'd6;
    sn = (x * sn) >> 30;
    cs = Q30One;
    cs = Q30One - ((x2 * cs) >> 30) / 64'd90;
    cs = Q30One - ((x2 * cs) >> 30) / 64'd56;
    cs = Q30One - ((x2 * cs) >> 30) / 64'd30;
    cs = Q30One - ((x2 * cs) >> 30) / 64'd12;
    cs = Q30One - ((x2 * cs) >> 30) / 64'd2;
    if (r >= (64'd1 << 29)) begin
      tmp = sn;
      sn  = cs;
      cs  = tmp;
    end
    unique case (p[31:30])
      2'd0: begin
        co = cs[31:0];
        si = sn[31:0];
      end
      2'd1: begin
        co = -sn[31:0];
        si = cs[31:0];
      end
      2'd2: begin
        co = -cs[31:0];
        si = -sn[31:0];
      end
      2'd3: begin
        co = sn[31:0];
        si = -cs[31:0];
      end
    endcase
    return {co, si};
  endfunction

  function automatic logic [63:0] isqrt_f(input logic [63:0] v);
    logic [63:0] r, b, rem;
    r   = '0;
    rem = v;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic hann_rom_t hann_rom_f();
    hann_rom_t t;
    logic [63:0] ph, cw;
    logic signed [63:0] c;
    for (int i = 0; i < WinLen; i++) begin
      ph   = ((64'(i) << 32) / 64'(WinLenM1)) & 64'hFFFF_FFFF;
      cw   = cos_sin_f(ph[31:0]);
      c    = {{32{cw[63]}}, cw[63:32]};
      t[i] = 16'((Q30One - c + (64'd1 << 15)) >> 16);
    end
    return t;
  endfunction

  function automatic tw_rom_t tw_cos_f();
    tw_rom_t t;
    logic [63:0] cw;
    for (int i = 0; i < HalfLen; i++) begin
      cw   = cos_sin_f(32'(64'(i) * TwStep));
      t[i] = cw[63:32];
    end
    return t;
  endfunction

  function automatic tw_rom_t tw_sin_f();
    tw_rom_t t;
    logic [63:0] cw;
    for (int i = 0; i < HalfLen; i++) begin
      cw   = cos_sin_f(32'(64'(i) * TwStep));
      t[i] = cw[31:0];
    end
    return t;
  endfunction

  function automatic logic [DvsW-1:0] win_sum_f();
    hann_rom_t t;
    logic [63:0] s;
    t = hann_rom_f();
    s = '0;
    for (int i = 0; i < WinLen; i++) s = s + 64'(t[i]);
    return DvsW'(s);
  endfunction

  function automatic logic [DvsW-1:0] win_rms_f();
    hann_rom_t t;
    logic [63:0] s;
    t = hann_rom_f();
    s = '0;
    for (int i = 0; i < WinLen; i++) s = s + 64'(t[i]) * 64'(t[i]);
    return DvsW'(isqrt_f(s));
  endfunction

  // Rounded-up reciprocal, so that (x * recip) >> ScaleShift equals (x << s) / d exactly
  // for every root x.
  function automatic logic [63:0] recip_f(input logic [DvsW-1:0] d, input int s);
    logic [127:0] num;
    num = 128'd1 << (ScaleShift + s);
    return 64'((num + 128'(d) - 128'd1) / 128'(d));
  endfunction

  function automatic logic [LogLen-1:0] bitrev_f(input logic [LogLen-1:0] v);
    logic [LogLen-1:0] r;
    for (int b = 0; b < LogLen; b++) r[LogLen-1-b] = v[b];
    return r;
  endfunction

  localparam hann_rom_t HannRom = hann_rom_f();
  localparam tw_rom_t   TwCos   = tw_cos_f();
  localparam tw_rom_t   TwSin   = tw_sin_f();
  localparam logic [DvsW-1:0] WinSum = win_sum_f();
  localparam logic [DvsW-1:0] WinRms = win_rms_f();
  localparam logic [63:0] RecipSine = recip_f(WinSum, 28);
  localparam logic [63:0] RecipRms  = recip_f(WinRms, 29);

endpackage

FILE: rtl/averaged_spectrum_analyzer.sv
// Read request: result strobed in the cycle after acceptance; the receiver cannot stall it.
// Sample push: busy_o stays low, except after the push that completes a window, when busy_o
// stays high through windowing, 7 x 64 butterflies and 64 bin magnitudes (mostly the
// bit-serial square root), and for longer when it also completes a measurement, each
// exported bin then passing through the divider and the log unit.
// Reset is asynchronous and active low; the spectrum reads as not valid until measured.
`include "averaged_spectrum_analyzer_defines.svh"

module averaged_spectrum_analyzer
  import asa_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     operation_i,
  input  logic signed [SampleBits-1:0] sample_value_i,
  input  logic [LogHalf-1:0]       bin_index_i,
  output logic                     valid_o,
  output logic signed [LevelW-1:0] bin_level_o,
  output logic                     bin_valid_o
);

  top_state_e state_q, state_d;

  logic [SigTypeW-1:0] sig_type_q;
  logic [FramesW-1:0]  meas_frames_q;
  logic [LogLen-1:0]   wpos_q;
  logic [LogLen:0]     win_cnt_q;
  logic [StageW-1:0]   stage_q;
  logic [LogHalf-1:0]  bf_q;
  logic [LogHalf-1:0]  kbin_q;
  logic [WisW-1:0]     wis_q;
  logic [CountW-1:0]   fc_q;
  logic [HalfLen-1:0]  sum_vld_q;
  logic                ready_q;
  logic                rd_vld_q, rd_rdy_q;

  logic accept, push, read;

  // Memory ports.
  logic [SampleBits-1:0] smp_rdata;
  logic                  smp_re;
  logic                  fft_we, fft_re;
  logic [LogLen-1:0]     fft_waddr, fft_raddr;
  logic [2*FftW-1:0]     fft_wdata, fft_rdata;
  logic                  sum_we, sum_re;
  logic [SumW-1:0]       sum_wdata, sum_rdata, sum_base;
  logic                  lvl_we;
  logic [LevelW-1:0]     lvl_rdata;

  // Arithmetic units.
  logic             div_start, div_done;
  logic [DivW-1:0]  div_dividend, div_quot, mag;
  logic [DvsW-1:0]  div_divisor;
  logic             root_start, root_done;
  logic [RootW-1:0] root;
  logic             log_start, log_done;
  logic signed [LevelW-1:0] log_level;

  // Magnitude scaling by a constant reciprocal, in two partial products.
  logic [63:0]        sc_recip;
  logic [31:0]        sc_half;
  logic [RootW+31:0]  sc_mul, sc_lo_q, sc_hi_q;
  logic [RootW+63:0]  sc_full;

  // Datapath registers.
  logic signed [FftW-1:0]   br_q, bi_q, ur_q, ui_q, tr_q, ti_q;
  logic signed [2*FftW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [FftW-1:0]   mul_a, mul_b;
  logic signed [2*FftW-1:0] mul_p;
  logic signed [2*FftW-1:0] tr_full, ti_full;

  // Butterfly addressing.
  logic [LogLen-1:0]  half, jj, grp, addr_a, addr_b;
  logic [LogHalf-1:0] tw_idx;
  logic signed [FftW-1:0] tw_c, tw_s;

  // Windowing.
  logic [LogLen-1:0]  widx;
  logic signed [32:0] wmul;
  logic signed [33:0] wrnd;
  logic signed [FftW-1:0] wval;

  assign accept = start_i && (state_q == StIdle);
  assign push   = accept && !operation_i;
  assign read   = accept && operation_i;

  assign half   = LogLen'(1) << stage_q;
  assign jj     = {1'b0, bf_q} & (half - 1'b1);
  assign grp    = {1'b0, bf_q} >> stage_q;
  assign addr_a = ((grp << stage_q) << 1) | jj;
  assign addr_b = addr_a | half;
  assign tw_idx = LogHalf'(jj << (StageW'(LogHalf) - stage_q));
  assign tw_c   = TwCos[tw_idx];
  assign tw_s   = TwSin[tw_idx];

  assign widx = LogLen'(win_cnt_q - 1'b1);
  assign wmul = $signed(smp_rdata) * $signed({1'b0, HannRom[widx]});
  assign wrnd = ($signed({wmul[32], wmul}) + (34'sd1 <<< (InShift - 1))) >>> InShift;
  assign wval = FftW'(wrnd);

  assign mul_p   = mul_a * mul_b;
  assign tr_full = (p1_q + p2_q + (64'sd1 <<< 29)) >>> 30;
  assign ti_full = (p3_q - p4_q + (64'sd1 <<< 29)) >>> 30;

  assign sc_recip = (sig_type_q == SigSine) ? RecipSine : RecipRms;
  assign sc_half  = (state_q == StMgScHi) ? sc_recip[63:32] : sc_recip[31:0];
  assign sc_mul   = (RootW + 32)'(root) * (RootW + 32)'(sc_half);
  assign sc_full  = {sc_hi_q, 32'd0} + (RootW + 64)'(sc_lo_q);

  assign sum_base = sum_vld_q[kbin_q] ? sum_rdata : '0;
  assign mag      = (DivW'(sc_full[RootW+63:ScaleShift]) < MagFloor) ? MagFloor :
                    DivW'(sc_full[RootW+63:ScaleShift]);

  always_comb begin
    state_d      = state_q;
    smp_re       = 1'b0;
    fft_we       = 1'b0;
    fft_waddr    = '0;
    fft_wdata    = '0;
    fft_re       = 1'b0;
    fft_raddr    = '0;
    sum_we       = 1'b0;
    sum_re       = 1'b0;
    sum_wdata    = '0;
    lvl_we       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    root_start   = 1'b0;
    log_start    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (push && wpos_q == LogLen'(WinLen - 1)) state_d = StWin;
      end
      StWin: begin
        // Read sample n while the windowed sample n-1 goes to its bit-reversed slot.
        smp_re = win_cnt_q < (LogLen + 1)'(WinLen);
        if (win_cnt_q != '0) begin
          fft_we    = 1'b1;
          fft_waddr = bitrev_f(widx);
          fft_wdata = {wval, {FftW{1'b0}}};
        end
        if (win_cnt_q == (LogLen + 1)'(WinLen)) state_d = StBfRdB;
      end
      StBfRdB: begin
        fft_re    = 1'b1;
        fft_raddr = addr_b;
        state_d   = StBfRdA;
      end
      StBfRdA: begin
        fft_re    = 1'b1;
        fft_raddr = addr_a;
        state_d   = StBfMul0;
      end
      StBfMul0: begin
        mul_a   = br_q;
        mul_b   = tw_c;
        state_d = StBfMul1;
      end
      StBfMul1: begin
        mul_a   = bi_q;
        mul_b   = tw_s;
        state_d = StBfMul2;
      end
      StBfMul2: begin
        mul_a   = bi_q;
        mul_b   = tw_c;
        state_d = StBfMul3;
      end
      StBfMul3: begin
        mul_a   = br_q;
        mul_b   = tw_s;
        state_d = StBfTw;
      end
      StBfTw: state_d = StBfWrA;
      StBfWrA: begin
        fft_we    = 1'b1;
        fft_waddr = addr_a;
        fft_wdata = {ur_q + tr_q, ui_q + ti_q};
        state_d   = StBfWrB;
      end
      StBfWrB: begin
        fft_we    = 1'b1;
        fft_waddr = addr_b;
        fft_wdata = {ur_q - tr_q, ui_q - ti_q};
        if (bf_q == LogHalf'(HalfLen - 1) && stage_q == StageW'(LogLen - 1)) begin
          state_d = StMgRd;
        end else begin
          state_d = StBfRdB;
        end
      end
      StMgRd: begin
        fft_re    = 1'b1;
        fft_raddr = {1'b0, kbin_q};
        sum_re    = 1'b1;
        state_d   = StMgSq0;
      end
      StMgSq0: begin
        mul_a   = fft_rdata[2*FftW-1:FftW];
        mul_b   = fft_rdata[2*FftW-1:FftW];
        state_d = StMgSq1;
      end
      StMgSq1: begin
        mul_a   = bi_q;
        mul_b   = bi_q;
        state_d = StMgRoot;
      end
      StMgRoot: begin
        root_start = 1'b1;
        state_d    = StMgRootWait;
      end
      StMgRootWait: begin
        if (root_done) state_d = StMgScLo;
      end
      StMgScLo: state_d = StMgScHi;
      StMgScHi: state_d = StMgAcc;
      StMgAcc: begin
        sum_we    = 1'b1;
        sum_wdata = sum_base + SumW'(mag);
        state_d   = (kbin_q == LogHalf'(HalfLen - 1)) ? StCheck : StMgRd;
      end
      StCheck: begin
        state_d = (fc_q >= CountW'(meas_frames_q)) ? StExRd : StIdle;
      end
      StExRd: begin
        sum_re  = 1'b1;
        state_d = StExDiv;
      end
      StExDiv: begin
        div_start    = 1'b1;
        div_dividend = DivW'(sum_base);
        div_divisor  = DvsW'(wis_q);
        state_d      = StExDivWait;
      end
      StExDivWait: begin
        if (div_done) begin
          log_start = 1'b1;
          state_d   = StExLogWait;
        end
      end
      StExLogWait: begin
        if (log_done) begin
          lvl_we  = 1'b1;
          state_d = (kbin_q == LogHalf'(HalfLen - 1)) ? StExEnd : StExRd;
        end
      end
      StExEnd: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      sig_type_q    <= SigTypeReset;
      meas_frames_q <= MeasFramesReset;
      wpos_q        <= '0;
      win_cnt_q     <= '0;
      stage_q       <= '0;
      bf_q          <= '0;
      kbin_q        <= '0;
      wis_q         <= '0;
      fc_q          <= '0;
      sum_vld_q     <= '0;
      ready_q       <= 1'b0;
      rd_vld_q      <= 1'b0;
      rd_rdy_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= read;
      if (read) rd_rdy_q <= ready_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgSignalType: sig_type_q    <= cfg_data_i[SigTypeW-1:0];
          CfgMeasFrames: meas_frames_q <= cfg_data_i[FramesW-1:0];
        endcase
      end
      if (push) wpos_q <= wpos_q + 1'b1;
      unique case (state_q)
        StIdle: win_cnt_q <= '0;
        StWin: begin
          win_cnt_q <= win_cnt_q + 1'b1;
          stage_q   <= '0;
          bf_q      <= '0;
        end
        StBfWrB: begin
          bf_q <= bf_q + 1'b1;
          if (bf_q == LogHalf'(HalfLen - 1)) begin
            stage_q <= stage_q + 1'b1;
            kbin_q  <= '0;
          end
        end
        StMgAcc: begin
          sum_vld_q[kbin_q] <= 1'b1;
          kbin_q            <= kbin_q + 1'b1;
          if (kbin_q == LogHalf'(HalfLen - 1)) begin
            wis_q <= wis_q + 1'b1;
            fc_q  <= fc_q + CountW'(WinLen);
          end
        end
        StExLogWait: if (log_done) kbin_q <= kbin_q + 1'b1;
        StExEnd: begin
          // The sums restart from zero for the next measurement.
          sum_vld_q <= '0;
          wis_q     <= '0;
          fc_q      <= '0;
          ready_q   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      // The second operand of the butterfly arrives in the cycle before the first.
      StBfRdA: begin
        br_q <= fft_rdata[2*FftW-1:FftW];
        bi_q <= fft_rdata[FftW-1:0];
      end
      default: ;
    endcase
    unique case (state_q)
      StBfMul0: begin
        p1_q <= mul_p;
        ur_q <= fft_rdata[2*FftW-1:FftW];
        ui_q <= fft_rdata[FftW-1:0];
      end
      StBfMul1: p2_q <= mul_p;
      StBfMul2: p3_q <= mul_p;
      StBfMul3: p4_q <= mul_p;
      StBfTw: begin
        tr_q <= FftW'(tr_full);
        ti_q <= FftW'(ti_full);
      end
      StMgSq0: begin
        p1_q <= mul_p;
        bi_q <= fft_rdata[FftW-1:0];
      end
      StMgSq1: p2_q <= mul_p;
      StMgScLo: sc_lo_q <= sc_mul;
      StMgScHi: sc_hi_q <= sc_mul;
      default: ;
    endcase
  end

  asa_ram #(.Width(SampleBits), .Depth(WinLen)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wpos_q),
    .wdata_i (sample_value_i),
    .re_i    (smp_re),
    .raddr_i (win_cnt_q[LogLen-1:0]),
    .rdata_o (smp_rdata)
  );

  asa_ram #(.Width(2 * FftW), .Depth(WinLen)) u_fft_ram (
    .clk_i   (clk_i),
    .we_i    (fft_we),
    .waddr_i (fft_waddr),
    .wdata_i (fft_wdata),
    .re_i    (fft_re),
    .raddr_i (fft_raddr),
    .rdata_o (fft_rdata)
  );

  asa_ram #(.Width(SumW), .Depth(HalfLen)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (kbin_q),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (kbin_q),
    .rdata_o (sum_rdata)
  );

  asa_ram #(.Width(LevelW), .Depth(HalfLen)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (kbin_q),
    .wdata_i (log_level),
    .re_i    (read),
    .raddr_i (bin_index_i),
    .rdata_o (lvl_rdata)
  );

  asa_isqrt u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (DivW'(p1_q + p2_q)),
    .done_o     (root_done),
    .root_o     (root)
  );

  asa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  asa_log2 u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .value_i (div_quot[SumW-1:0]),
    .done_o  (log_done),
    .level_o (log_level)
  );

  assign busy_o      = state_q != StIdle;
  assign valid_o     = rd_vld_q;
  assign bin_valid_o = rd_rdy_q;
  assign bin_level_o = rd_rdy_q ? lvl_rdata : '0;

  `ASA_ASSERT_IMP(a_result_follows_read, clk_i, rst_ni, valid_o,
                  $past(start_i && !busy_o && operation_i), "result without a read request")
  `ASA_ASSERT_IMP(a_unmeasured_reads_zero, clk_i, rst_ni, valid_o && !bin_valid_o,
                  bin_level_o == '0, "level not zero before a measurement")
  `ASA_ASSERT_NXT(a_full_window_processes, clk_i, rst_ni,
                  push && wpos_q == LogLen'(WinLen - 1), busy_o,
                  "full window did not start processing")

endmodule

FILE: rtl/asa_ram.sv
module asa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/asa_div.sv
module asa_div
  import asa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [DivW-1:0] quo_q;
  logic [DvsW-1:0] rem_q, dvs_q;
  logic [DvsW:0]   shifted;
  logic            fits;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(DivW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= fits ? DvsW'(shifted - {1'b0, dvs_q}) : shifted[DvsW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/asa_isqrt.sv
module asa_isqrt
  import asa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  radicand_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic            run_q, done_q;
  logic [DivW-1:0] v_q, r_q, bit_q, cand;

  // One result bit per cycle; the trial bit walks down two places a step.
  assign cand = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && bit_q[0]) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= DivW'(1) << (DivW - 2);
    end else if (run_q) begin
      if (v_q >= cand) begin
        v_q <= v_q - cand;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[RootW-1:0];

endmodule

FILE: rtl/asa_log2.sv
module asa_log2
  import asa_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [SumW-1:0]          value_i,
  output logic                     done_o,
  output logic signed [LevelW-1:0] level_o
);

  localparam int ExpW = $clog2(SumW);

  log_state_e state_q, state_d;

  logic [SumW-1:0]          n_q;
  logic [ExpW-1:0]          e_q;
  logic [31:0]              m_q;
  logic [15:0]              frac_q;
  logic [3:0]               k_q;
  logic signed [46:0]       prod_q;
  logic signed [LevelW-1:0] level_q;
  logic                     done_q;
  logic [63:0]              sq;
  logic [31:0]              sq_t;
  logic signed [6:0]        e_rel;
  logic signed [22:0]       log_q16;
  logic signed [47:0]       rnd;
  logic signed [15:0]       lv;

  assign sq      = 64'(m_q) * 64'(m_q);
  assign sq_t    = sq[61:30];
  assign e_rel   = $signed({1'b0, e_q}) - 7'sd32;
  assign log_q16 = $signed({e_rel, frac_q});
  assign rnd     = ($signed({prod_q[46], prod_q}) + (48'sd1 <<< 31)) >>> 32;
  assign lv      = rnd[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LgIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == LgRnd);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LgIdle: if (start_i) state_d = LgNorm;
      LgNorm: if (n_q[SumW-1]) state_d = LgSqr;
      LgSqr:  if (k_q == 4'd15) state_d = LgMul;
      LgMul:  state_d = LgRnd;
      LgRnd:  state_d = LgIdle;
      default: state_d = LgIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LgIdle: begin
        if (start_i) begin
          n_q <= (value_i == '0) ? SumW'(1) : value_i;
          e_q <= ExpW'(SumW - 1);
        end
      end
      LgNorm: begin
        if (n_q[SumW-1]) begin
          m_q    <= {1'b0, n_q[SumW-1:SumW-31]};
          frac_q <= '0;
          k_q    <= '0;
        end else begin
          n_q <= n_q << 1;
          e_q <= e_q - 1'b1;
        end
      end
      LgSqr: begin
        // Each squaring of the mantissa yields one fraction bit.
        m_q    <= sq_t[31] ? (sq_t >> 1) : sq_t;
        frac_q <= {frac_q[14:0], sq_t[31]};
        k_q    <= k_q + 1'b1;
      end
      LgMul: prod_q <= log_q16 * $signed({1'b0, LevelK});
      LgRnd: begin
        if (lv < 16'(LevelMin)) begin
          level_q <= LevelW'(LevelMin);
        end else if (lv > 16'(LevelMax)) begin
          level_q <= LevelW'(LevelMax);
        end else begin
          level_q <= lv[LevelW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule
